// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/bmpb_pkg.sv =====
// types, constants and helpers of the banked memory and sound port bus
package bmpb_pkg;

    localparam int UPPER_BANKS = 8;
    localparam int FIXED_BANKS = 3;
    localparam int BANK_OFS_W  = 14;
    localparam int UB_W        = $clog2(UPPER_BANKS);
    localparam int BANK_W      = $clog2(FIXED_BANKS + UPPER_BANKS);
    localparam int STORE_DEPTH = (FIXED_BANKS + UPPER_BANKS) * (1 << BANK_OFS_W);
    localparam int ADDR_W      = BANK_W + BANK_OFS_W;
    localparam int NUM_REGS    = 16;
    localparam int SNAP_REGS   = 14;

    localparam logic [3:0]        REG_ENV   = 4'd13;
    localparam logic [3:0]        LAST_IDX  = 4'(SNAP_REGS - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [7:0]        BYTE_IDLE = 8'hFF;

    typedef enum logic [2:0] {
        ACT_MEM_RD   = 3'd0,
        ACT_MEM_WR   = 3'd1,
        ACT_PORT_IN  = 3'd2,
        ACT_PORT_OUT = 3'd3,
        ACT_SNAP     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SNAP
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [3:0]  reg_index;
        logic        last;
        logic [31:0] out_write_count;
        logic [31:0] r13_write_count;
    } t_result;

    typedef struct packed {
        logic              accept;
        logic              clear;
        logic [ADDR_W-1:0] clr_addr;
        logic              snap_emit;
        logic [3:0]        snap_idx;
    } t_cmd;

    // page number folded into the available upper banks
    function automatic logic [UB_W-1:0] wrap_bank(input logic [2:0] v);
        logic [3:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 4; i++) begin
            if (r >= 4'(UPPER_BANKS)) begin
                r = r - 4'(UPPER_BANKS);
            end
        end
        return r[UB_W-1:0];
    endfunction

endpackage

// ===== sv/bmpb_ctrl.sv =====
// controller: clearing sweep, request acceptance and snapshot sequencing
`include "assert_macros.svh"

module bmpb_ctrl import bmpb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_action i_action,
    output logic    o_busy,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [3:0]        r_cnt, n_cnt;
    logic              accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cnt      = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && i_action == ACT_SNAP) begin
                    n_state = ST_SNAP;
                    n_cnt   = 4'd1;
                end
            end
            ST_SNAP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_busy             = (r_state != ST_IDLE);
        o_cmd.accept       = accept;
        o_cmd.clear        = (r_state == ST_CLEAR);
        o_cmd.clr_addr     = r_clr_addr;
        o_cmd.snap_emit    = (r_state == ST_SNAP) || (accept && i_action == ACT_SNAP);
        o_cmd.snap_idx     = (r_state == ST_SNAP) ? r_cnt : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cnt      <= n_cnt;
        end
    end

    `ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (r_state == ST_CLEAR), "reset did not start clear")
    `ASSERT_CLK(a_clr_step, (r_state == ST_CLEAR && r_clr_addr != CLR_LAST) |=> (r_state == ST_CLEAR && r_clr_addr == $past(r_clr_addr) + 1'b1), "clear sweep skipped")
    `ASSERT_CLK(a_snap_start, (o_cmd.snap_emit && r_state == ST_IDLE) |=> (r_state == ST_SNAP && r_cnt == 4'd1), "snapshot did not start")
    `ASSERT_CLK(a_snap_end, (r_state == ST_SNAP && r_cnt == LAST_IDX) |=> (r_state == ST_IDLE), "snapshot did not end")

endmodule

// ===== sv/bmpb_dp.sv =====
// datapath: banked byte store, paging, sound registers, counters and result register
module bmpb_dp import bmpb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_req    i_req,
    output logic    o_valid,
    output t_result o_result
);

    logic [7:0] mem [STORE_DEPTH];

    logic [UB_W-1:0] r_upper, n_upper;
    logic [3:0]      r_sel, n_sel;
    logic [7:0]      r_regs [NUM_REGS];
    logic [7:0]      n_regs [NUM_REGS];
    logic            r_fresh, n_fresh;
    logic [31:0]     r_wcnt, n_wcnt;
    logic [31:0]     r_ecnt, n_ecnt;
    logic            r_valid, n_valid;
    logic            r_sel_mem, n_sel_mem;
    logic [7:0]      r_data, n_data;
    logic [3:0]      r_idx, n_idx;
    logic            r_last, n_last;
    logic [7:0]      r_rdata;

    logic [1:0]        slot;
    logic [BANK_W-1:0] bank;
    logic [ADDR_W-1:0] map_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              is_page, is_select, is_write;
    logic [3:0]        rd_idx;
    logic [7:0]        rd_val;
    logic [7:0]        snap_val;
    logic [7:0]        port_in_val;

    always_comb begin
        slot = i_req.address[15:14];
        if (slot == 2'b11) begin
            bank = BANK_W'(FIXED_BANKS) + BANK_W'(r_upper);
        end else begin
            bank = BANK_W'(slot);
        end
        map_addr = {bank, i_req.address[BANK_OFS_W-1:0]};

        is_page   = !i_req.address[15] && !i_req.address[1];
        is_select = (slot == 2'b11) && !i_req.address[1];
        is_write  = (slot == 2'b10) && !i_req.address[1];

        rd_idx      = i_cmd.snap_emit ? i_cmd.snap_idx : r_sel;
        rd_val      = r_regs[rd_idx];
        snap_val    = (i_cmd.snap_idx == REG_ENV && !r_fresh) ? BYTE_IDLE : rd_val;
        port_in_val = (is_select && r_sel < 4'(SNAP_REGS)) ? rd_val : BYTE_IDLE;

        mem_we    = i_cmd.clear || (i_cmd.accept && i_req.action == ACT_MEM_WR);
        mem_waddr = i_cmd.clear ? i_cmd.clr_addr : map_addr;
        mem_wdata = i_cmd.clear ? 8'd0 : i_req.write_data;
    end

    always_comb begin
        n_upper   = r_upper;
        n_sel     = r_sel;
        n_regs    = r_regs;
        n_fresh   = r_fresh;
        n_wcnt    = r_wcnt;
        n_ecnt    = r_ecnt;
        n_valid   = 1'b0;
        n_sel_mem = r_sel_mem;
        n_data    = r_data;
        n_idx     = r_idx;
        n_last    = r_last;
        if (i_cmd.snap_emit) begin
            n_valid   = 1'b1;
            n_sel_mem = 1'b0;
            n_data    = snap_val;
            n_idx     = i_cmd.snap_idx;
            n_last    = (i_cmd.snap_idx == LAST_IDX);
            if (i_cmd.snap_idx == LAST_IDX) begin
                n_fresh = 1'b0;
            end
        end else if (i_cmd.accept) begin
            n_valid   = 1'b1;
            n_sel_mem = (i_req.action == ACT_MEM_RD);
            n_data    = 8'd0;
            n_idx     = 4'd0;
            n_last    = 1'b1;
            case (i_req.action)
                ACT_PORT_IN: begin
                    n_data = port_in_val;
                end
                ACT_PORT_OUT: begin
                    if (is_page) begin
                        n_upper = wrap_bank(i_req.write_data[2:0]);
                    end else if (is_select) begin
                        n_sel = i_req.write_data[3:0];
                    end else if (is_write) begin
                        n_regs[r_sel] = i_req.write_data;
                        n_wcnt        = r_wcnt + 1'b1;
                        if (r_sel == REG_ENV) begin
                            n_ecnt  = r_ecnt + 1'b1;
                            n_fresh = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= '0;
            r_sel   <= '0;
            r_regs  <= '{default: 8'd0};
            r_fresh <= 1'b0;
            r_wcnt  <= '0;
            r_ecnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_upper <= n_upper;
            r_sel   <= n_sel;
            r_regs  <= n_regs;
            r_fresh <= n_fresh;
            r_wcnt  <= n_wcnt;
            r_ecnt  <= n_ecnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_mem <= n_sel_mem;
        r_data    <= n_data;
        r_idx     <= n_idx;
        r_last    <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[map_addr];
    end

    assign o_valid                  = r_valid;
    assign o_result.read_data       = r_sel_mem ? r_rdata : r_data;
    assign o_result.reg_index       = r_idx;
    assign o_result.last            = r_last;
    assign o_result.out_write_count = r_wcnt;
    assign o_result.r13_write_count = r_ecnt;

endmodule

// ===== sv/banked_memory_and_psg_port_bus.sv =====
// top level of the banked memory and sound-chip port bus
//
// A request is taken at a rising edge where start is high and busy is low.
// i_req carries the action, the 16-bit address or port number and the write byte.
// Every result appears on o_result for exactly one cycle, marked by o_valid;
// the receiver cannot hold results off, so it must take each one as it comes.
// Memory read/write, port in and port out give one result, in the cycle after the
// request; busy stays low, so such requests are taken on every cycle.
// A snapshot gives 14 results on consecutive cycles, reg_index 0 to 13, last set
// on the final one; busy is high after the snapshot is taken and falls in the cycle
// that shows the last result, in which a new request is taken.
// Reads follow earlier writes in request order, including back-to-back ones.
// After reset the byte store is swept to zero, one byte per cycle, all 180224
// bytes with eight upper banks; busy is high during the sweep.
// The snapshot length is set by SNAP_REGS; the sound register file is read through
// its single read port, one register per cycle.
module banked_memory_and_psg_port_bus import bmpb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_valid,
    output t_result o_result
);

    t_cmd cmd;

    bmpb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    bmpb_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== test/bank_bus_checker.sv =====
// checker that predicts and compares the results of the banked memory and sound port bus
module bank_bus_checker import bmpb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_req    i_req,
    input  logic    i_valid,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BANK_BYTES  = 1 << BANK_OFS_W;
    localparam logic [15:0] SLOT1_BASE  = 16'h4000;
    localparam logic [15:0] SLOT2_BASE  = 16'h8000;
    localparam logic [15:0] SLOT3_BASE  = 16'hC000;
    localparam logic [15:0] DECODE_MASK = 16'hC002;
    localparam logic [15:0] PAGE_MASK   = 16'h8002;
    localparam logic [15:0] SELECT_PORT = 16'hC000;
    localparam logic [15:0] WRITE_PORT  = 16'h8000;

    logic [7:0]  byte_store [STORE_DEPTH];
    logic [2:0]  page_reg;
    logic [3:0]  sel_reg;
    logic [7:0]  psg_regs [NUM_REGS];
    logic        env_fresh;
    logic [31:0] write_count;
    logic [31:0] env_write_count;
    t_result     due_results [$];
    int          fail_total = 0;
    int          pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            byte_store[i] = 8'h00;
        end
    end

    function automatic int unsigned store_index(input logic [15:0] addr);
        int unsigned bank;
        if (addr < SLOT1_BASE) begin
            bank = 0;
        end else if (addr < SLOT2_BASE) begin
            bank = 1;
        end else if (addr < SLOT3_BASE) begin
            bank = 2;
        end else begin
            bank = FIXED_BANKS + (int'(page_reg) % UPPER_BANKS);
        end
        return bank * BANK_BYTES + int'(addr[BANK_OFS_W-1:0]);
    endfunction

    task automatic predict_request(input t_req req);
        t_result res;
        res = '0;
        res.last = 1'b1;
        case (req.action)
            ACT_MEM_RD: begin
                res.read_data = byte_store[store_index(req.address)];
            end
            ACT_MEM_WR: begin
                byte_store[store_index(req.address)] = req.write_data;
            end
            ACT_PORT_IN: begin
                res.read_data = BYTE_IDLE;
                if ((req.address & DECODE_MASK) == SELECT_PORT && sel_reg < SNAP_REGS) begin
                    res.read_data = psg_regs[sel_reg];
                end
            end
            ACT_PORT_OUT: begin
                if ((req.address & PAGE_MASK) == 16'h0000) begin
                    page_reg = req.write_data[2:0];
                end else if ((req.address & DECODE_MASK) == SELECT_PORT) begin
                    sel_reg = req.write_data[3:0];
                end else if ((req.address & DECODE_MASK) == WRITE_PORT) begin
                    psg_regs[sel_reg] = req.write_data;
                    write_count++;
                    if (sel_reg == REG_ENV) begin
                        env_write_count++;
                        env_fresh = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.out_write_count = write_count;
        res.r13_write_count = env_write_count;
        if (req.action == ACT_SNAP) begin
            for (int i = 0; i < SNAP_REGS; i++) begin
                res.read_data = (i == REG_ENV && !env_fresh) ? BYTE_IDLE : psg_regs[i];
                res.reg_index = 4'(i);
                res.last      = (4'(i) == LAST_IDX);
                due_results.push_back(res);
            end
            env_fresh = 1'b0;
        end else begin
            due_results.push_back(res);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("unexpected result: rd=%02h idx=%0d last=%0b wc=%0d ec=%0d",
                         got.read_data, got.reg_index, got.last,
                         got.out_write_count, got.r13_write_count);
            end
        end else begin
            want = due_results.pop_front();
            if (got.read_data !== want.read_data || got.reg_index !== want.reg_index ||
                got.last !== want.last || got.out_write_count !== want.out_write_count ||
                got.r13_write_count !== want.r13_write_count) begin
                fail_total++;
                if (fail_total <= 10) begin
                    $display("mismatch: expected rd=%02h idx=%0d last=%0b wc=%0d ec=%0d",
                             want.read_data, want.reg_index, want.last,
                             want.out_write_count, want.r13_write_count);
                    $display("          got      rd=%02h idx=%0d last=%0b wc=%0d ec=%0d",
                             got.read_data, got.reg_index, got.last,
                             got.out_write_count, got.r13_write_count);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            page_reg        = '0;
            sel_reg         = '0;
            env_fresh       = 1'b0;
            write_count     = '0;
            env_write_count = '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                psg_regs[i] = 8'h00;
            end
            due_results.delete();
        end else begin
            if (i_valid) begin
                check_result(i_result);
            end
            if (i_start && !i_busy) begin
                predict_request(i_req);
            end
        end
        pending_total = due_results.size();
    end

endmodule

// ===== test/banked_memory_and_psg_port_bus_tb.sv =====
// testbench top: clock, reset, request stimulus and verdict for the port bus
module banked_memory_and_psg_port_bus_tb import bmpb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    t_req    req = '0;
    logic    busy;
    logic    valid;
    t_result result;
    int      fail_count;
    int      pending;
    bit      idle_on = 1'b1;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    banked_memory_and_psg_port_bus u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_req    (req),
        .busy     (busy),
        .o_valid  (valid),
        .o_result (result)
    );

    bank_bus_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_valid      (valid),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_req bus_req(input t_action act, input logic [15:0] addr,
                                     input logic [7:0] data);
        t_req r;
        r.action     = act;
        r.address    = addr;
        r.write_data = data;
        return r;
    endfunction

    // clustered addresses so that reads often land on written bytes
    function automatic logic [15:0] near_address();
        logic [15:0] a;
        a[15:14] = 2'($urandom_range(0, 3));
        a[13:4]  = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        a[3:0]   = 4'($urandom_range(0, 15));
        return a;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        r.action     = ACT_MEM_RD;
        r.address    = 16'($urandom_range(0, 16'hFFFF));
        r.write_data = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            r.action  = ACT_MEM_WR;
            r.address = near_address();
        end else if (pick < 44) begin
            r.address = near_address();
        end else if (pick < 50) begin
            r.action     = ACT_PORT_OUT;
            r.address[15] = 1'b0;
            r.address[1]  = 1'b0;
        end else if (pick < 60) begin
            r.action         = ACT_PORT_OUT;
            r.address[15:14] = 2'b11;
            r.address[1]     = 1'b0;
            if ($urandom_range(0, 1)) begin
                r.write_data[3:0] = REG_ENV;
            end
        end else if (pick < 72) begin
            r.action         = ACT_PORT_OUT;
            r.address[15:14] = 2'b10;
            r.address[1]     = 1'b0;
        end else if (pick < 76) begin
            r.action = ACT_PORT_OUT;
        end else if (pick < 90) begin
            r.action = ACT_PORT_IN;
            if ($urandom_range(0, 3) != 0) begin
                r.address[15:14] = 2'b11;
                r.address[1]     = 1'b0;
            end
        end else if (pick < 95) begin
            r.action = ACT_SNAP;
        end
        return r;
    endfunction

    task automatic issue(input t_req r);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    task automatic run_directed();
        issue(bus_req(ACT_SNAP,     16'h0000, 8'h00));
        issue(bus_req(ACT_MEM_WR,   16'h0000, 8'hFF));
        issue(bus_req(ACT_MEM_WR,   16'h3FFF, 8'h01));
        issue(bus_req(ACT_MEM_WR,   16'h4000, 8'h80));
        issue(bus_req(ACT_MEM_WR,   16'h7FFF, 8'h7F));
        issue(bus_req(ACT_MEM_WR,   16'h8000, 8'hAA));
        issue(bus_req(ACT_MEM_WR,   16'hBFFF, 8'h55));
        issue(bus_req(ACT_MEM_WR,   16'hFFFF, 8'hA5));
        issue(bus_req(ACT_PORT_OUT, 16'h7FFD, 8'hFF));
        issue(bus_req(ACT_MEM_RD,   16'hFFFF, 8'h00));
        issue(bus_req(ACT_MEM_WR,   16'hC000, 8'h5A));
        issue(bus_req(ACT_PORT_OUT, 16'h0000, 8'h00));
        issue(bus_req(ACT_MEM_RD,   16'hFFFF, 8'h00));
        issue(bus_req(ACT_MEM_RD,   16'h0000, 8'h00));
        issue(bus_req(ACT_MEM_RD,   16'hBFFF, 8'h00));
        issue(bus_req(ACT_PORT_OUT, 16'hFFFD, 8'h0D));
        issue(bus_req(ACT_PORT_OUT, 16'hBFFD, 8'h3C));
        issue(bus_req(ACT_PORT_IN,  16'hFFFD, 8'h00));
        issue(bus_req(ACT_SNAP,     16'hFFFF, 8'hFF));
        issue(bus_req(ACT_SNAP,     16'h0000, 8'h00));
        issue(bus_req(ACT_PORT_OUT, 16'hFFFD, 8'hFF));
        issue(bus_req(ACT_PORT_OUT, 16'hBFFD, 8'h00));
        issue(bus_req(ACT_PORT_IN,  16'hFFFD, 8'h00));
        issue(bus_req(ACT_PORT_IN,  16'h0001, 8'h00));
        issue(bus_req(ACT_PORT_OUT, 16'h4002, 8'h77));
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int n = 0; n < 480; n++) begin
            idle_on = (n < 150 || n >= 300);
            issue(random_request());
        end
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== banked_memory_and_psg_port_bus.f =====
+incdir+sv
sv/bmpb_pkg.sv
sv/bmpb_ctrl.sv
sv/bmpb_dp.sv
sv/banked_memory_and_psg_port_bus.sv
test/bank_bus_checker.sv
test/banked_memory_and_psg_port_bus_tb.sv
